// ----- design/bkmb_pkg.sv -----
// Package for the brightness knob and mode button unit.
// Holds the shared types, register indexes and reset constants.
// No dependencies; every other file in the design imports it.
package bkmb_pkg;

    // Number of lighting modes; the mode wraps to 0 after the last one.
    localparam int MODE_COUNT = 4;

    // Field widths.
    localparam int KNOB_W  = 10;
    localparam int LEVEL_W = 8;
    localparam int MODE_W  = 2;
    localparam int TIMER_W = 16;
    localparam int SUM_W   = 12;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SAMPLE_INTERVAL = 3'd0,
        REG_DEBOUNCE_TICKS  = 3'd1,
        REG_TOLERANCE       = 3'd2,
        REG_OFF_FLOOR       = 3'd3,
        REG_MIN_LEVEL       = 3'd4,
        REG_MAX_LEVEL       = 3'd5,
        REG_HOLD_MODE       = 3'd6
    } cfg_index_t;

    // Reset values of the configuration registers.
    localparam logic [TIMER_W-1:0] RST_SAMPLE_INTERVAL = 16'd60;
    localparam logic [TIMER_W-1:0] RST_DEBOUNCE_TICKS  = 16'd40;
    localparam logic [LEVEL_W-1:0] RST_TOLERANCE       = 8'd2;
    localparam logic [LEVEL_W-1:0] RST_OFF_FLOOR       = 8'd5;
    localparam logic [LEVEL_W-1:0] RST_MIN_LEVEL       = 8'd0;
    localparam logic [LEVEL_W-1:0] RST_MAX_LEVEL       = 8'd255;
    localparam logic [MODE_W-1:0]  RST_HOLD_MODE       = 2'd1;

    // All configuration registers as one bundle.
    typedef struct packed {
        logic [TIMER_W-1:0] sample_interval;
        logic [TIMER_W-1:0] debounce_ticks;
        logic [LEVEL_W-1:0] tolerance;
        logic [LEVEL_W-1:0] off_floor;
        logic [LEVEL_W-1:0] min_level;
        logic [LEVEL_W-1:0] max_level;
        logic [MODE_W-1:0]  hold_mode;
    } cfg_t;

    // Knob path status after one item.
    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               set;
        logic               off;
    } knob_result_t;

    // Button path status after one item.
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              advanced;
    } button_result_t;

endpackage

// ----- design/bkmb_cfg_regs.sv -----
// Configuration register file of the brightness knob and mode button unit.
// Depends on bkmb_pkg for the register indexes, reset values and cfg_t.
module bkmb_cfg_regs
    import bkmb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write; an index beyond the list leaves everything as is.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_SAMPLE_INTERVAL: cfg_next.sample_interval = cfg_data;
                REG_DEBOUNCE_TICKS:  cfg_next.debounce_ticks  = cfg_data;
                REG_TOLERANCE:       cfg_next.tolerance = cfg_data[LEVEL_W-1:0];
                REG_OFF_FLOOR:       cfg_next.off_floor = cfg_data[LEVEL_W-1:0];
                REG_MIN_LEVEL:       cfg_next.min_level = cfg_data[LEVEL_W-1:0];
                REG_MAX_LEVEL:       cfg_next.max_level = cfg_data[LEVEL_W-1:0];
                REG_HOLD_MODE:       cfg_next.hold_mode = cfg_data[MODE_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    // Register storage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sample_interval <= RST_SAMPLE_INTERVAL;
            cfg_reg.debounce_ticks  <= RST_DEBOUNCE_TICKS;
            cfg_reg.tolerance       <= RST_TOLERANCE;
            cfg_reg.off_floor       <= RST_OFF_FLOOR;
            cfg_reg.min_level       <= RST_MIN_LEVEL;
            cfg_reg.max_level       <= RST_MAX_LEVEL;
            cfg_reg.hold_mode       <= RST_HOLD_MODE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- design/bkmb_knob.sv -----
// Knob path: sample timer, four-sample accumulator, hysteresis and clamp.
// Depends on bkmb_pkg for widths, cfg_t and knob_result_t.
module bkmb_knob
    import bkmb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [KNOB_W-1:0]  knob_sample,
    input  logic [MODE_W-1:0]  cur_mode,
    input  cfg_t               cfg,
    output knob_result_t       result
);

    logic [TIMER_W-1:0] sample_timer_reg, sample_timer_next;
    logic [1:0]         sample_count_reg, sample_count_next;
    logic [SUM_W-1:0]   sample_sum_reg,   sample_sum_next;
    logic [LEVEL_W-1:0] level_reg,        level_next;

    logic [SUM_W-1:0]   sum_add;
    logic [LEVEL_W-1:0] avg_level;
    logic [LEVEL_W-1:0] diff;
    logic               set_flag;
    logic               off_flag;

    // Accumulate on each sample; the fourth sample closes an average.
    always_comb
    begin
        sample_timer_next = sample_timer_reg;
        sample_count_next = sample_count_reg;
        sample_sum_next   = sample_sum_reg;
        level_next        = level_reg;
        set_flag          = 1'b0;
        off_flag          = 1'b0;
        sum_add   = sample_sum_reg + SUM_W'(knob_sample);
        avg_level = sum_add[SUM_W-1:SUM_W-LEVEL_W];
        diff      = (avg_level >= level_reg) ? (avg_level - level_reg)
                                             : (level_reg - avg_level);
        if (step)
        begin
            if (sample_timer_reg <= TIMER_W'(1))
            begin
                sample_timer_next = cfg.sample_interval;
                if (sample_count_reg == 2'd3)
                begin
                    sample_count_next = 2'd0;
                    sample_sum_next   = '0;
                    if (cur_mode != cfg.hold_mode && diff >= cfg.tolerance)
                    begin
                        if (avg_level < cfg.off_floor)
                        begin
                            off_flag = 1'b1;
                        end
                        else
                        begin
                            // Max takes priority when the limits are inverted.
                            if (avg_level >= cfg.max_level)
                                level_next = cfg.max_level;
                            else if (avg_level <= cfg.min_level)
                                level_next = cfg.min_level;
                            else
                                level_next = avg_level;
                            set_flag = 1'b1;
                        end
                    end
                end
                else
                begin
                    sample_count_next = sample_count_reg + 2'd1;
                    sample_sum_next   = sum_add;
                end
            end
            else
            begin
                sample_timer_next = sample_timer_reg - TIMER_W'(1);
            end
        end
    end

    // Knob path state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_timer_reg <= RST_SAMPLE_INTERVAL;
            sample_count_reg <= 2'd0;
            sample_sum_reg   <= '0;
            level_reg        <= RST_MAX_LEVEL;
        end
        else
        begin
            sample_timer_reg <= sample_timer_next;
            sample_count_reg <= sample_count_next;
            sample_sum_reg   <= sample_sum_next;
            level_reg        <= level_next;
        end
    end

    assign result.level = level_next;
    assign result.set   = set_flag;
    assign result.off   = off_flag;

endmodule

// ----- design/bkmb_button.sv -----
// Button path: change detector, debounce countdown and mode counter.
// Depends on bkmb_pkg for widths, MODE_COUNT, cfg_t and button_result_t.
module bkmb_button
    import bkmb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic               button_level,
    input  cfg_t               cfg,
    output logic [MODE_W-1:0]  cur_mode,
    output button_result_t     result
);

    logic [MODE_W-1:0]  mode_reg,           mode_next;
    logic [TIMER_W-1:0] debounce_timer_reg, debounce_timer_next;
    logic               debounce_busy_reg,  debounce_busy_next;
    logic               last_button_reg,    last_button_next;

    logic [MODE_W:0]    mode_inc;
    logic               adv_flag;

    // A level change restarts the countdown; expiry with the pin low is a press.
    always_comb
    begin
        mode_next           = mode_reg;
        debounce_timer_next = debounce_timer_reg;
        debounce_busy_next  = debounce_busy_reg;
        last_button_next    = last_button_reg;
        adv_flag            = 1'b0;
        mode_inc            = {1'b0, mode_reg} + (MODE_W+1)'(1);
        if (step)
        begin
            last_button_next = button_level;
            if (button_level != last_button_reg)
            begin
                debounce_timer_next = cfg.debounce_ticks;
                debounce_busy_next  = 1'b1;
            end
            else if (debounce_busy_reg)
            begin
                if (debounce_timer_reg <= TIMER_W'(1))
                begin
                    debounce_busy_next  = 1'b0;
                    debounce_timer_next = '0;
                    if (!button_level)
                    begin
                        adv_flag  = 1'b1;
                        mode_next = (mode_inc >= (MODE_W+1)'(MODE_COUNT))
                                    ? '0 : mode_inc[MODE_W-1:0];
                    end
                end
                else
                begin
                    debounce_timer_next = debounce_timer_reg - TIMER_W'(1);
                end
            end
        end
    end

    // Button path state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg           <= '0;
            debounce_timer_reg <= '0;
            debounce_busy_reg  <= 1'b0;
            last_button_reg    <= 1'b1;
        end
        else
        begin
            mode_reg           <= mode_next;
            debounce_timer_reg <= debounce_timer_next;
            debounce_busy_reg  <= debounce_busy_next;
            last_button_reg    <= last_button_next;
        end
    end

    assign cur_mode        = mode_reg;
    assign result.mode     = mode_next;
    assign result.advanced = adv_flag;

endmodule

// ----- design/brightness_knob_and_mode_button_unit.sv -----
// Top level of the brightness knob and mode button unit.
// Depends on bkmb_pkg, bkmb_cfg_regs, bkmb_knob and bkmb_button.

// Each accepted item (one knob reading and one button pin level) gives exactly
// one result item with the mode, the brightness, and the set, off and advance
// strobes of that tick. An item is held in an input register, processed in one
// pass of logic through the knob and button paths, and its result lands in an
// output register. With no stall the unit takes one item per clock and the
// result is valid on the clock edge after the one that accepted the item. The
// input register is freed when the output register is empty or being taken in
// the same cycle, so a stalled result holds at most one more item behind it.
// Configuration writes are taken on any cycle with cfg_we high and act from
// the next item on.
module brightness_knob_and_mode_button_unit
    import bkmb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // Input channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [KNOB_W-1:0]     knob_sample,
    input  logic                  button_level,
    // Output channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [MODE_W-1:0]     mode,
    output logic [LEVEL_W-1:0]    brightness,
    output logic                  brightness_set,
    output logic                  lights_off,
    output logic                  mode_advanced
);

    cfg_t           cfg;
    knob_result_t   knob_res;
    button_result_t button_res;
    logic [MODE_W-1:0] cur_mode;

    logic              in_valid_reg;
    logic [KNOB_W-1:0] knob_reg;
    logic              button_reg;
    logic              out_valid_reg, out_valid_next;
    logic [MODE_W-1:0] mode_reg;
    logic [LEVEL_W-1:0] brightness_reg;
    logic              set_reg;
    logic              off_reg;
    logic              adv_reg;
    logic              fire;
    logic              in_take;

    // The held item is processed when the output register can take its result.
    assign fire     = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !fire;
    assign in_take  = in_valid && !in_stall;

    bkmb_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bkmb_knob u_knob (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (fire),
        .knob_sample (knob_reg),
        .cur_mode    (cur_mode),
        .cfg         (cfg),
        .result      (knob_res)
    );

    bkmb_button u_button (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (fire),
        .button_level (button_reg),
        .cfg          (cfg),
        .cur_mode     (cur_mode),
        .result       (button_res)
    );

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            knob_reg   <= knob_sample;
            button_reg <= button_level;
        end
    end

    // Output register control.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            mode_reg       <= button_res.mode;
            brightness_reg <= knob_res.level;
            set_reg        <= knob_res.set;
            off_reg        <= knob_res.off;
            adv_reg        <= button_res.advanced;
        end
    end

    assign out_valid      = out_valid_reg;
    assign mode           = mode_reg;
    assign brightness     = brightness_reg;
    assign brightness_set = set_reg;
    assign lights_off     = off_reg;
    assign mode_advanced  = adv_reg;

`ifndef SYNTHESIS
    // A result never both sets the brightness and turns the lights off.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(brightness_set && lights_off))
        else $error("brightness_set and lights_off raised together");

    // An advance strobe always goes with a new mode value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && button_res.advanced) |=> (cur_mode != $past(cur_mode)))
        else $error("mode advance did not change the mode");

    // The input side only stalls while an item is held.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled with room to take an item");

    // Brightness changes only on a result that reports a set.
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && out_valid && !knob_res.set) |-> (knob_res.level == brightness))
        else $error("brightness moved without a set strobe");
`endif

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for brightness_knob_and_mode_button_unit.
// An item-level predictor tracks every accepted item; depends on bkmb_pkg and the unit itself.
// Stimulus mixes directed corners, back-pressure and randomized setting phases.
`timescale 1ns / 1ps

module tb;
    import bkmb_pkg::*;

    // Index past the register list; writes to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    localparam int HOLD_OFF_CYCLES = 100;
    localparam int IDLE_LIMIT      = 2000;
    localparam int DRAIN_SLACK     = 4;
    localparam int END_SLACK       = 8;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_PERIODIC, STALL_HEAVY} stall_style_t;

    // One expected result item.
    typedef struct {
        logic [MODE_W-1:0]  mode;
        logic [LEVEL_W-1:0] brightness;
        logic               set;
        logic               off;
        logic               advanced;
    } tick_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [KNOB_W-1:0]     knob_sample = '0;
    logic                  button_level = 1'b1;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [MODE_W-1:0]     mode;
    logic [LEVEL_W-1:0]    brightness;
    logic                  brightness_set;
    logic                  lights_off;
    logic                  mode_advanced;

    // Predictor state and its copy of the registers.
    cfg_t                  live_cfg;
    logic [MODE_W-1:0]     pred_mode;
    logic [LEVEL_W-1:0]    pred_level;
    logic [1:0]            pred_sample_cnt;
    logic [SUM_W-1:0]      pred_sample_acc;
    logic [TIMER_W-1:0]    pred_sample_tmr;
    logic [TIMER_W-1:0]    pred_deb_tmr;
    logic                  pred_deb_busy;
    logic                  pred_btn_last;

    tick_result_t          expected_ticks[$];
    int                    mismatch_count = 0;
    int                    idle_cycles = 0;

    // Shared stimulus state.
    stall_style_t          stall_style = STALL_LIGHT;
    int                    hold_off_requests = 0;
    int                    burst_left = 0;
    int                    knob_base = 512;
    logic                  btn_now = 1'b1;
    int                    btn_run = 0;

    brightness_knob_and_mode_button_unit uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .knob_sample    (knob_sample),
        .button_level   (button_level),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .mode           (mode),
        .brightness     (brightness),
        .brightness_set (brightness_set),
        .lights_off     (lights_off),
        .mode_advanced  (mode_advanced)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predictor reset: registers and state as they come out of reset.
    function automatic void reset_controller();
        live_cfg.sample_interval = RST_SAMPLE_INTERVAL;
        live_cfg.debounce_ticks  = RST_DEBOUNCE_TICKS;
        live_cfg.tolerance       = RST_TOLERANCE;
        live_cfg.off_floor       = RST_OFF_FLOOR;
        live_cfg.min_level       = RST_MIN_LEVEL;
        live_cfg.max_level       = RST_MAX_LEVEL;
        live_cfg.hold_mode       = RST_HOLD_MODE;
        pred_mode       = '0;
        pred_level      = RST_MAX_LEVEL;
        pred_sample_cnt = '0;
        pred_sample_acc = '0;
        pred_sample_tmr = RST_SAMPLE_INTERVAL;
        pred_deb_tmr    = '0;
        pred_deb_busy   = 1'b0;
        pred_btn_last   = 1'b1;
    endfunction

    // Advances the predicted controller by one tick and returns the result item.
    function automatic tick_result_t advance_controller(input logic [KNOB_W-1:0] knob,
                                                        input logic btn);
        tick_result_t r;
        logic [LEVEL_W-1:0] avg;
        logic [LEVEL_W-1:0] diff;
        r.set = 1'b0;
        r.off = 1'b0;
        r.advanced = 1'b0;

        // Knob path runs first and sees the mode from before this tick.
        if (pred_sample_tmr <= TIMER_W'(1))
        begin
            pred_sample_acc = pred_sample_acc + SUM_W'(knob);
            if (pred_sample_cnt == 2'd3)
            begin
                avg  = pred_sample_acc[SUM_W-1:4];
                diff = (avg >= pred_level) ? avg - pred_level : pred_level - avg;
                if (pred_mode != live_cfg.hold_mode && diff >= live_cfg.tolerance)
                begin
                    if (avg < live_cfg.off_floor)
                        r.off = 1'b1;
                    else
                    begin
                        // The maximum wins when the limits are inverted.
                        if (avg >= live_cfg.max_level)
                            pred_level = live_cfg.max_level;
                        else if (avg <= live_cfg.min_level)
                            pred_level = live_cfg.min_level;
                        else
                            pred_level = avg;
                        r.set = 1'b1;
                    end
                end
                pred_sample_cnt = '0;
                pred_sample_acc = '0;
            end
            else
                pred_sample_cnt = pred_sample_cnt + 2'd1;
            pred_sample_tmr = live_cfg.sample_interval;
        end
        else
            pred_sample_tmr = pred_sample_tmr - TIMER_W'(1);

        // Button path: any edge restarts the debounce countdown.
        if (btn != pred_btn_last)
        begin
            pred_deb_tmr  = live_cfg.debounce_ticks;
            pred_deb_busy = 1'b1;
        end
        else if (pred_deb_busy)
        begin
            if (pred_deb_tmr <= TIMER_W'(1))
            begin
                pred_deb_busy = 1'b0;
                pred_deb_tmr  = '0;
                if (btn == 1'b0)
                begin
                    if (pred_mode == MODE_W'(MODE_COUNT - 1))
                        pred_mode = '0;
                    else
                        pred_mode = pred_mode + MODE_W'(1);
                    r.advanced = 1'b1;
                end
            end
            else
                pred_deb_tmr = pred_deb_tmr - TIMER_W'(1);
        end
        pred_btn_last = btn;

        r.mode = pred_mode;
        r.brightness = pred_level;
        return r;
    endfunction

    // Every accepted input item produces one expected result.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            expected_ticks.push_back(advance_controller(knob_sample, button_level));
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge clk)
    begin : result_check
        tick_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_ticks.size() == 0)
            begin
                mismatch_count++;
                $error("result item arrived with no item outstanding");
            end
            else
            begin
                want = expected_ticks.pop_front();
                if (mode !== want.mode)
                begin
                    mismatch_count++;
                    $error("mode: expected %0d, got %0d", want.mode, mode);
                end
                if (brightness !== want.brightness)
                begin
                    mismatch_count++;
                    $error("brightness: expected %0d, got %0d", want.brightness, brightness);
                end
                if (brightness_set !== want.set)
                begin
                    mismatch_count++;
                    $error("brightness_set: expected %0d, got %0d", want.set, brightness_set);
                end
                if (lights_off !== want.off)
                begin
                    mismatch_count++;
                    $error("lights_off: expected %0d, got %0d", want.off, lights_off);
                end
                if (mode_advanced !== want.advanced)
                begin
                    mismatch_count++;
                    $error("mode_advanced: expected %0d, got %0d", want.advanced,
                           mode_advanced);
                end
            end
        end
    end

    // Watchdog: ends the run when nothing has moved for too long.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !rst_n)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $error("no handshake for %0d cycles", IDLE_LIMIT);
            $display("status: fail");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Receiver: stalls on its own pattern, with a long hold-off on request.
    initial
    begin : receiver
        int served;
        int phase;
        served = 0;
        phase = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off_requests != served)
            begin
                served++;
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            phase = (phase + 1) % 7;
            case (stall_style)
                STALL_NONE:     out_stall <= 1'b0;
                STALL_LIGHT:    out_stall <= ($urandom_range(0, 99) < 25);
                STALL_PERIODIC: out_stall <= (phase < 3);
                default:        out_stall <= ($urandom_range(0, 99) < 70);
            endcase
        end
    end

    // Offers one item and returns once it has been accepted.
    task automatic send_tick(input logic [KNOB_W-1:0] knob, input logic btn);
        in_valid     <= 1'b1;
        knob_sample  <= knob;
        button_level <= btn;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic pause_sender(input int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Sender works in bursts; some bursts are long enough to run without gaps.
    task automatic sender_gap();
        if (burst_left > 0)
            burst_left--;
        else
        begin
            pause_sender($urandom_range(1, 12));
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 90)
                                                     : $urandom_range(1, 12);
        end
    endtask

    // Stops offering and waits until every outstanding result has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_ticks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_SLACK) @(posedge clk);
    endtask

    // One register write; cfg_we stays high until the caller drops it.
    task automatic put_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            REG_SAMPLE_INTERVAL: live_cfg.sample_interval = data;
            REG_DEBOUNCE_TICKS:  live_cfg.debounce_ticks  = data;
            REG_TOLERANCE:       live_cfg.tolerance       = data[LEVEL_W-1:0];
            REG_OFF_FLOOR:       live_cfg.off_floor       = data[LEVEL_W-1:0];
            REG_MIN_LEVEL:       live_cfg.min_level       = data[LEVEL_W-1:0];
            REG_MAX_LEVEL:       live_cfg.max_level       = data[LEVEL_W-1:0];
            REG_HOLD_MODE:       live_cfg.hold_mode       = data[MODE_W-1:0];
            default: ;
        endcase
    endtask

    // Writes all registers while idle; unused upper data bits carry noise.
    task automatic load_settings(input cfg_t c);
        drain_results();
        put_register(REG_SAMPLE_INTERVAL, c.sample_interval);
        put_register(REG_DEBOUNCE_TICKS, c.debounce_ticks);
        put_register(REG_TOLERANCE, {8'($urandom), c.tolerance});
        put_register(REG_OFF_FLOOR, {8'($urandom), c.off_floor});
        put_register(REG_MIN_LEVEL, {8'($urandom), c.min_level});
        put_register(REG_MAX_LEVEL, {8'($urandom), c.max_level});
        put_register(REG_HOLD_MODE, {14'($urandom), c.hold_mode});
        put_register(REG_UNUSED, 16'($urandom));
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Knob readings cluster around a wandering base so averages settle;
    // the button mostly makes clean presses and releases, with some bounce.
    task automatic send_random_ticks(input int count, input int run_max, input bit bursty);
        int k;
        for (int n = 0; n < count; n++)
        begin
            case ($urandom_range(0, 19))
                0: knob_base = $urandom_range(0, 1023);
                1: knob_base = 0;
                2: knob_base = 1023;
                default: ;
            endcase
            k = knob_base + int'($urandom_range(0, 16)) - 8;
            if (k < 0)
                k = 0;
            if (k > 1023)
                k = 1023;
            if ($urandom_range(0, 29) == 0)
                k = $urandom_range(0, 1023);

            if (btn_run == 0)
            begin
                btn_now = ~btn_now;
                btn_run = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2)
                                                      : $urandom_range(1, run_max + 6);
            end
            btn_run--;

            send_tick(KNOB_W'(k), btn_now);
            if (bursty)
                sender_gap();
        end
    endtask

    // Reset values: default interval and debounce are too long to act here.
    task automatic test_reset_state();
        send_tick(10'd0, 1'b1);
        send_tick(10'd1023, 1'b0);
        send_tick(10'd1023, 1'b0);
        send_tick(10'd0, 1'b1);
    endtask

    // Zero interval and debounce, full clamp, lights off, and inverted limits.
    task automatic test_directed_corners();
        load_settings('{sample_interval: 16'd0, debounce_ticks: 16'd0, tolerance: 8'd0,
                        off_floor: 8'd5, min_level: 8'd0, max_level: 8'd255,
                        hold_mode: 2'd3});
        // Full-scale average clamps to the maximum; a press advances the mode.
        for (int i = 0; i < 4; i++)
            send_tick(10'd1023, (i == 0));
        // Zero average lands below the floor; the release does not advance.
        for (int i = 0; i < 4; i++)
            send_tick(10'd0, (i != 0));
        for (int i = 0; i < 4; i++)
            send_tick(10'd512, 1'b1);

        // Minimum above maximum: high levels give the maximum, low ones the minimum.
        load_settings('{sample_interval: 16'd1, debounce_ticks: 16'd2, tolerance: 8'd0,
                        off_floor: 8'd0, min_level: 8'd200, max_level: 8'd100,
                        hold_mode: 2'd0});
        for (int i = 0; i < 4; i++)
            send_tick(10'd1023, 1'b1);
        for (int i = 0; i < 4; i++)
            send_tick(10'd320, 1'b1);
    endtask

    // Receiver holds off while the sender keeps offering, so the input stalls.
    task automatic test_backpressure();
        stall_style = STALL_NONE;
        hold_off_requests++;
        send_random_ticks(60, 4, 1'b0);
        drain_results();
    endtask

    // Several setting phases, the extremes first, with varied receiver behavior.
    task automatic test_random_settings();
        cfg_t c;
        for (int p = 0; p < 8; p++)
        begin
            if (p == 0)
                c = '{sample_interval: 16'd1, debounce_ticks: 16'd1, tolerance: 8'd0,
                      off_floor: 8'd0, min_level: 8'd0, max_level: 8'd0, hold_mode: 2'd0};
            else if (p == 1)
                c = '{sample_interval: 16'd2, debounce_ticks: 16'hFFFF, tolerance: 8'd255,
                      off_floor: 8'd255, min_level: 8'd255, max_level: 8'd255,
                      hold_mode: 2'd3};
            else
            begin
                c.sample_interval = TIMER_W'($urandom_range(0, 4));
                c.debounce_ticks  = TIMER_W'($urandom_range(0, 6));
                c.tolerance       = LEVEL_W'(($urandom_range(0, 3) == 0)
                                             ? $urandom_range(0, 255)
                                             : $urandom_range(0, 6));
                c.off_floor       = LEVEL_W'($urandom_range(0, 64));
                c.min_level       = LEVEL_W'($urandom_range(0, 100));
                c.max_level       = LEVEL_W'($urandom_range(60, 255));
                c.hold_mode       = MODE_W'($urandom_range(0, 3));
            end
            stall_style = stall_style_t'(p % 4);
            load_settings(c);
            send_random_ticks(170, (c.debounce_ticks > 20) ? 20 : int'(c.debounce_ticks),
                              1'b1);
        end
    endtask

    // Longest sample interval last, since its countdown outlasts the run.
    task automatic test_long_interval();
        stall_style = STALL_HEAVY;
        load_settings('{sample_interval: 16'hFFFF, debounce_ticks: 16'd3, tolerance: 8'd2,
                        off_floor: 8'd5, min_level: 8'd0, max_level: 8'd255,
                        hold_mode: 2'd1});
        send_random_ticks(20, 3, 1'b1);
    endtask

    initial
    begin
        reset_controller();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_directed_corners();
        test_backpressure();
        test_random_settings();
        test_long_interval();

        drain_results();
        repeat (END_SLACK) @(posedge clk);
        if (mismatch_count == 0 && expected_ticks.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/bkmb_pkg.sv
design/bkmb_cfg_regs.sv
design/bkmb_knob.sv
design/bkmb_button.sv
design/brightness_knob_and_mode_button_unit.sv
tb/tb.sv
